// ----- sv/sli_pkg.sv -----
package sli_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int WORD_W       = 32;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [WORD_W-1:0] operand;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] entry_value;
    logic [5:0]               entry_count;
    logic                     last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_PUT,
    ST_DEL,
    ST_DUMP
  } state_t;

endpackage

// ----- sv/sorted_list_insert_delete.sv -----
// Sorted store of signed 32-bit words, ascending, duplicates allowed.
// Command channel: request is taken at a clock edge with start high and busy
// low. Commands: insert (before the first entry not smaller), delete (all
// equal entries, gaps closed), dump (every entry in order).
// Result channel: each result word sits on result for one cycle with strobe
// high; the receiver cannot stall, so words are never held or repeated.
// Every command ends with one word that has last set; a dump of n entries
// gives n words, one per cycle.
// Work is paced by the one-read one-write entry RAM, walked one entry a cycle:
//   insert: walks down from the top entry, moving each entry not smaller up one,
//   then writes the operand; answered from idle when the store is empty or full
//   delete: reads every entry in turn, writing back the others; dump: one word per entry
//   ignored code / empty dump / empty delete: answered from idle
// busy stays high while a walk runs; one command is worked on at a time.
// Reset (rst, synchronous) empties the store; the RAM itself is not cleared,
// since only entries below the count are ever read.
module sorted_list_insert_delete #(
  parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  sli_pkg::req_t request,
  output logic          strobe,
  output sli_pkg::res_t result
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  sli_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] kept, kept_next;
  logic [IW-1:0] cur, cur_next;
  logic signed [sli_pkg::WORD_W-1:0] op_q;
  logic strobe_next;
  sli_pkg::res_t result_next;

  logic                       we;
  logic [IW-1:0]              waddr, raddr;
  logic [sli_pkg::WORD_W-1:0] wdata, rdata;

  sli_ram #(
    .WIDTH(sli_pkg::WORD_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign busy = (state != sli_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= sli_pkg::ST_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      strobe <= strobe_next;
    end
    kept   <= kept_next;
    cur    <= cur_next;
    result <= result_next;
    if (state == sli_pkg::ST_IDLE && start) begin
      op_q <= request.operand;
    end
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    kept_next   = kept;
    cur_next    = cur;
    strobe_next = 1'b0;
    result_next = '0;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr       = '0;

    case (state)
      sli_pkg::ST_IDLE: begin
        if (start) begin
          result_next.last   = 1'b1;
          result_next.status = sli_pkg::STAT_DONE;
          case (request.command)
            sli_pkg::CMD_INSERT: begin
              if (count == CW'(CAPACITY)) begin
                strobe_next             = 1'b1;
                result_next.status      = sli_pkg::STAT_FULL;
                result_next.entry_count = 6'(count);
              end else if (count == '0) begin
                we                      = 1'b1;
                wdata                   = request.operand;
                count_next              = CW'(1);
                strobe_next             = 1'b1;
                result_next.entry_count = 6'(count_next);
              end else begin
                raddr      = IW'(count - 1'b1);
                cur_next   = raddr;
                state_next = sli_pkg::ST_INS;
              end
            end
            sli_pkg::CMD_DELETE: begin
              if (count == '0) begin
                strobe_next = 1'b1;
              end else begin
                cur_next   = '0;
                kept_next  = '0;
                state_next = sli_pkg::ST_DEL;
              end
            end
            sli_pkg::CMD_DUMP: begin
              if (count == '0) begin
                strobe_next        = 1'b1;
                result_next.status = sli_pkg::STAT_EMPTY;
              end else begin
                cur_next   = '0;
                state_next = sli_pkg::ST_DUMP;
              end
            end
            default: begin
              strobe_next             = 1'b1;
              result_next.entry_count = 6'(count);
            end
          endcase
        end
      end

      // walk down from the top, moving each larger-or-equal entry up one
      sli_pkg::ST_INS: begin
        we    = 1'b1;
        waddr = IW'(cur + 1'b1);
        if ($signed(rdata) < op_q) begin
          wdata                   = op_q;
          count_next              = count + 1'b1;
          strobe_next             = 1'b1;
          result_next.last        = 1'b1;
          result_next.entry_count = 6'(count_next);
          state_next              = sli_pkg::ST_IDLE;
        end else begin
          wdata = rdata;
          if (cur == '0) begin
            state_next = sli_pkg::ST_PUT;
          end else begin
            raddr    = cur - 1'b1;
            cur_next = raddr;
          end
        end
      end

      sli_pkg::ST_PUT: begin
        we                      = 1'b1;
        wdata                   = op_q;
        count_next              = count + 1'b1;
        strobe_next             = 1'b1;
        result_next.last        = 1'b1;
        result_next.entry_count = 6'(count_next);
        state_next              = sli_pkg::ST_IDLE;
      end

      // compaction: writes land at or below the entry just read
      sli_pkg::ST_DEL: begin
        if (rdata != op_q) begin
          we        = 1'b1;
          waddr     = IW'(kept);
          wdata     = rdata;
          kept_next = kept + 1'b1;
        end
        if (cur == IW'(count - 1'b1)) begin
          count_next              = kept_next;
          strobe_next             = 1'b1;
          result_next.last        = 1'b1;
          result_next.entry_count = 6'(kept_next);
          state_next              = sli_pkg::ST_IDLE;
        end else begin
          raddr    = cur + 1'b1;
          cur_next = raddr;
        end
      end

      sli_pkg::ST_DUMP: begin
        strobe_next             = 1'b1;
        result_next.status      = sli_pkg::STAT_DONE;
        result_next.entry_value = rdata;
        result_next.entry_count = 6'(count);
        if (cur == IW'(count - 1'b1)) begin
          result_next.last = 1'b1;
          state_next       = sli_pkg::ST_IDLE;
        end else begin
          raddr    = cur + 1'b1;
          cur_next = raddr;
        end
      end

      default: begin
        state_next = sli_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/sli_ram.sv -----
module sli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/sv/sorted_store_checker.sv -----
module sorted_store_checker
  import sli_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t request,
  input  logic strobe,
  input  res_t result,
  output int   errors,
  output int   outstanding,
  output int   commands_taken,
  output int   words_checked,
  output int   full_rejects
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [WORD_W-1:0] held_values[$];
  res_t                     awaited_words[$];
  int                       err_count  = 0;
  int                       cmd_count  = 0;
  int                       word_count = 0;
  int                       full_count = 0;

  function automatic void push_word(logic [1:0] st, logic signed [WORD_W-1:0] v, int cnt,
                                    logic lst);
    res_t r;
    r.status      = st;
    r.entry_value = v;
    r.entry_count = 6'(cnt);
    r.last        = lst;
    awaited_words.push_back(r);
  endfunction

  function automatic void model_command(req_t w);
    int                       n;
    int                       pos;
    logic signed [WORD_W-1:0] val;
    logic signed [WORD_W-1:0] kept[$];
    n   = held_values.size();
    val = $signed(w.operand);
    case (w.command)
      CMD_INSERT: begin
        if (n >= CAPACITY) begin
          push_word(STAT_FULL, '0, n, 1'b1);
          full_count++;
        end else begin
          pos = 0;
          while (pos < n && held_values[pos] < val) pos++;
          held_values.insert(pos, val);
          push_word(STAT_DONE, '0, n + 1, 1'b1);
        end
      end
      CMD_DELETE: begin
        foreach (held_values[i]) begin
          if (held_values[i] != val) kept.push_back(held_values[i]);
        end
        held_values = kept;
        push_word(STAT_DONE, '0, held_values.size(), 1'b1);
      end
      CMD_DUMP: begin
        if (n == 0) begin
          push_word(STAT_EMPTY, '0, 0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) push_word(STAT_DONE, held_values[i], n, i == n - 1);
        end
      end
      default: begin
        push_word(STAT_DONE, '0, n, 1'b1);
      end
    endcase
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst) begin
      if (strobe) begin
        if (awaited_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %p", $time, result);
          err_count++;
        end else begin
          want = awaited_words.pop_front();
          word_count++;
          check_field("status", want.status, result.status);
          check_field("entry_value", $signed(want.entry_value), $signed(result.entry_value));
          check_field("entry_count", want.entry_count, result.entry_count);
          check_field("last", want.last, result.last);
        end
      end
      if (start && !busy) begin
        cmd_count++;
        model_command(request);
      end
    end
    errors         <= err_count;
    outstanding    <= awaited_words.size();
    commands_taken <= cmd_count;
    words_checked  <= word_count;
    full_rejects   <= full_count;
  end

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
  import sli_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]        CMD_UNUSED  = 2'd3;
  localparam logic signed [31:0] VAL_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN     = 32'sh8000_0000;
  localparam int                CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t request;
  logic strobe;
  res_t result;

  int errors;
  int outstanding;
  int commands_taken;
  int words_checked;
  int full_rejects;
  int idle_pct;
  int cycle_count = 0;

  sorted_list_insert_delete u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result)
  );

  sorted_store_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .request        (request),
    .strobe         (strobe),
    .result         (result),
    .errors         (errors),
    .outstanding    (outstanding),
    .commands_taken (commands_taken),
    .words_checked  (words_checked),
    .full_rejects   (full_rejects)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // start stays high from one word to the next unless a gap is drawn
  task automatic send_word(input logic [1:0] cmd, input logic signed [31:0] val);
    int   gap;
    req_t w;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.command = cmd;
    w.operand = val;
    start   <= 1'b1;
    request <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // half the picks come from a small pool so duplicates and delete hits are common
  function automatic logic signed [31:0] pick_operand();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $signed(32'($urandom_range(0, 15))) - 32'sd8;
    if (sel == 5) begin
      case ($urandom_range(0, 5))
        0: return VAL_MAX;
        1: return VAL_MIN;
        2: return VAL_MAX - 32'sd1;
        3: return VAL_MIN + 32'sd1;
        4: return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    return $signed($urandom);
  endfunction

  function automatic logic [1:0] pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return CMD_INSERT;
    if (r < 70) return CMD_DELETE;
    if (r < 92) return CMD_DUMP;
    return CMD_UNUSED;
  endfunction

  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    request  = '0;
    idle_pct = 9;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_word(CMD_DUMP, 32'sd0);
    send_word(CMD_DELETE, 32'sd5);
    send_word(CMD_UNUSED, 32'sd0);
    send_word(CMD_INSERT, 32'sd0);
    send_word(CMD_INSERT, VAL_MAX);
    send_word(CMD_INSERT, VAL_MIN);
    send_word(CMD_INSERT, -32'sd1);
    send_word(CMD_INSERT, 32'sd1);
    send_word(CMD_INSERT, 32'sd0);
    send_word(CMD_INSERT, VAL_MIN);
    send_word(CMD_INSERT, VAL_MAX);
    send_word(CMD_DUMP, VAL_MAX);
    send_word(CMD_DELETE, 32'sd7);
    send_word(CMD_DELETE, 32'sd0);
    send_word(CMD_DELETE, VAL_MAX);
    send_word(CMD_DUMP, VAL_MIN);
    send_word(CMD_UNUSED, -32'sd1);
    send_word(CMD_DELETE, VAL_MIN);
    send_word(CMD_DELETE, -32'sd1);
    send_word(CMD_DELETE, 32'sd1);
    send_word(CMD_DUMP, 32'sd0);

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: idle_pct = 9;
        1: idle_pct = 80;
        default: idle_pct = 0;
      endcase
      // fill past capacity so the store-full rejection is hit, then read it all
      repeat (34) send_word(CMD_INSERT, pick_operand());
      send_word(CMD_DUMP, pick_operand());
      repeat (25) send_word(pick_command(), pick_operand());
    end

    start <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d commands (insert, delete, dump, unused code) at three idle rates,",
             commands_taken);
    $display("checked %0d result words, %0d of them store-full rejections.",
             words_checked, full_rejects);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
